// ----- design/rogm_pkg.sv -----
// Shared types, constants and helpers for the rotated occupancy grid merge unit.
// No dependencies; every other design file but rogm_ram imports this package.
`timescale 1ns / 1ps

package rogm_pkg;

  // Store of the second grid: depth must be a power of two.
  localparam int STORE_CELLS = 65536;
  localparam int MAX_SIDE    = 256;

  localparam int ADDR_W    = $clog2(STORE_CELLS);
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int CELL_W    = 8;
  localparam int COORD_W   = 10;
  localparam int TRIG_W    = 16;
  localparam int DIM_W     = 9;
  localparam int LOAD_IDX_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Offset from a shift is one bit wider than a coordinate.
  localparam int DELTA_W = COORD_W + 1;
  // Product of an offset and a Q2.14 coefficient.
  localparam int PROD_W  = DELTA_W + TRIG_W;
  // Sum of two products plus the rounding bias.
  localparam int SUM_W   = PROD_W + 1;
  localparam int FRAC_W  = 14;
  localparam int MAP_W   = SUM_W - FRAC_W;
  // Linear index before wrapping to the store depth.
  localparam int LIN_W   = 2 * SIDE_W + 1;

  localparam logic signed [SUM_W-1:0]  ROUND_HALF   = SUM_W'(1 << (FRAC_W - 1));
  localparam logic signed [CELL_W-1:0] CELL_UNKNOWN = -8'sd1;

  // Request kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_FUSE = 1'b1;

  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t CFG_COS      = 3'd0;
  localparam cfg_idx_t CFG_SIN      = 3'd1;
  localparam cfg_idx_t CFG_SHIFT_X  = 3'd2;
  localparam cfg_idx_t CFG_SHIFT_Y  = 3'd3;
  localparam cfg_idx_t CFG_FIRST_W  = 3'd4;
  localparam cfg_idx_t CFG_FIRST_H  = 3'd5;
  localparam cfg_idx_t CFG_SECOND_W = 3'd6;
  localparam cfg_idx_t CFG_SECOND_H = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ADDR,
    ST_READ,
    ST_MERGE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_we;
    logic capture;
    logic mul_en;
    logic sum_en;
    logic addr_en;
    logic rd_en;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Grid sides above the supported maximum are held at the maximum.
  function automatic side_t clamp_side(input logic [DIM_W-1:0] v);
    side_t r;
    if (32'(v) > MAX_SIDE) begin
      r = side_t'(MAX_SIDE);
    end else begin
      r = side_t'(v);
    end
    return r;
  endfunction

endpackage

// ----- design/rotated_occupancy_grid_merge_unit.sv -----
// Top level of the rotated occupancy grid merge unit.
// Depends on rogm_pkg, rogm_ctrl, rogm_dp and rogm_ram.
`timescale 1ns / 1ps

// A load request writes one cell of the second grid into a 65536 x 8 on-chip
// store as it is taken. A fuse request maps its cell through the configured
// Q2.14 rotation and translation, reads the store and returns one merged cell
// after capture, multiply, round and bound check, index, store read and merge;
// no new request is taken until the merge has loaded the output register, and
// the merge waits while a stalled result sits there. A finished result waits
// there while the next request is taken. The store is not cleared at reset:
// a cell must be loaded before a fuse request maps onto it. Configuration must
// be written only while no request is in flight; the unit does not enforce it.

module rotated_occupancy_grid_merge_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  rogm_pkg::cfg_idx_t                    cfg_index_i,
  input  logic [rogm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  kind_i,
  input  logic [rogm_pkg::LOAD_IDX_W-1:0]       load_index_i,
  input  logic signed [rogm_pkg::CELL_W-1:0]    load_value_i,
  input  logic signed [rogm_pkg::COORD_W-1:0]   cell_x_i,
  input  logic signed [rogm_pkg::COORD_W-1:0]   cell_y_i,
  input  logic signed [rogm_pkg::CELL_W-1:0]    first_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rogm_pkg::CELL_W-1:0]    fused_value_o,
  output logic                                  first_hit_o,
  output logic                                  second_hit_o
);

  import rogm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  rogm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Mapping, store and merge.
  rogm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .load_index_i  (load_index_i),
    .load_value_i  (load_value_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .first_value_i (first_value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .fused_value_o (fused_value_o),
    .first_hit_o   (first_hit_o),
    .second_hit_o  (second_hit_o)
  );

endmodule

// ----- design/rogm_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; no package dependency.
`timescale 1ns / 1ps

module rogm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rogm_ctrl.sv -----
// Controller of the merge unit: sequences one request through the datapath.
// Depends on rogm_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps

module rogm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  rogm_pkg::dp_status_t status_i,
  output rogm_pkg::dp_cmd_t   cmd_o
);

  import rogm_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && kind_i == KIND_FUSE) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_ADDR;
      ST_ADDR: state_d = ST_READ;
      ST_READ: state_d = ST_MERGE;
      ST_MERGE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_we = in_valid_i && kind_i == KIND_LOAD;
        cmd_o.capture = in_valid_i && kind_i == KIND_FUSE;
      end
      ST_MUL:   cmd_o.mul_en   = 1'b1;
      ST_SUM:   cmd_o.sum_en   = 1'b1;
      ST_ADDR:  cmd_o.addr_en  = 1'b1;
      ST_READ:  cmd_o.rd_en    = 1'b1;
      ST_MERGE: cmd_o.out_load = status_i.out_free;
      default:  cmd_o          = '0;
    endcase
  end

endmodule

// ----- design/rogm_dp.sv -----
// Datapath of the merge unit: configuration registers, coordinate mapping,
// second grid store, merge and output register. Depends on rogm_pkg and rogm_ram.
`timescale 1ns / 1ps

module rogm_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  rogm_pkg::cfg_idx_t                    cfg_index_i,
  input  logic [rogm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic [rogm_pkg::LOAD_IDX_W-1:0]       load_index_i,
  input  logic signed [rogm_pkg::CELL_W-1:0]    load_value_i,
  input  logic signed [rogm_pkg::COORD_W-1:0]   cell_x_i,
  input  logic signed [rogm_pkg::COORD_W-1:0]   cell_y_i,
  input  logic signed [rogm_pkg::CELL_W-1:0]    first_value_i,
  input  rogm_pkg::dp_cmd_t                     cmd_i,
  output rogm_pkg::dp_status_t                  status_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rogm_pkg::CELL_W-1:0]    fused_value_o,
  output logic                                  first_hit_o,
  output logic                                  second_hit_o
);

  import rogm_pkg::*;

  // Configuration registers.
  logic signed [TRIG_W-1:0]  cos_q, sin_q;
  logic signed [COORD_W-1:0] shift_x_q, shift_y_q;
  side_t first_w_q, first_h_q, second_w_q, second_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q      <= TRIG_W'(16384);
      sin_q      <= '0;
      shift_x_q  <= '0;
      shift_y_q  <= '0;
      first_w_q  <= clamp_side(9'd256);
      first_h_q  <= clamp_side(9'd256);
      second_w_q <= clamp_side(9'd256);
      second_h_q <= clamp_side(9'd256);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COS:      cos_q      <= cfg_data_i;
        CFG_SIN:      sin_q      <= cfg_data_i;
        CFG_SHIFT_X:  shift_x_q  <= cfg_data_i[COORD_W-1:0];
        CFG_SHIFT_Y:  shift_y_q  <= cfg_data_i[COORD_W-1:0];
        CFG_FIRST_W:  first_w_q  <= clamp_side(cfg_data_i[DIM_W-1:0]);
        CFG_FIRST_H:  first_h_q  <= clamp_side(cfg_data_i[DIM_W-1:0]);
        CFG_SECOND_W: second_w_q <= clamp_side(cfg_data_i[DIM_W-1:0]);
        CFG_SECOND_H: second_h_q <= clamp_side(cfg_data_i[DIM_W-1:0]);
        default: ;
      endcase
    end
  end

  // Capture stage: first grid test and offsets from the translation.
  logic signed [DELTA_W-1:0] dx_q, dy_q, dx_d, dy_d;
  logic signed [CELL_W-1:0]  v1_q;
  logic                      hit1_q, hit1_d;

  assign dx_d = DELTA_W'(cell_x_i) - DELTA_W'(shift_x_q);
  assign dy_d = DELTA_W'(cell_y_i) - DELTA_W'(shift_y_q);
  assign hit1_d = !cell_x_i[COORD_W-1] && !cell_y_i[COORD_W-1] &&
                  (32'(cell_x_i[COORD_W-2:0]) < 32'(first_w_q)) &&
                  (32'(cell_y_i[COORD_W-2:0]) < 32'(first_h_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      v1_q   <= first_value_i;
      hit1_q <= hit1_d;
    end
  end

  // Multiply stage: the four rotation products.
  logic signed [PROD_W-1:0] p_xc_q, p_ys_q, p_xs_q, p_yc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_xc_q <= PROD_W'(dx_q) * PROD_W'(cos_q);
      p_ys_q <= PROD_W'(dy_q) * PROD_W'(sin_q);
      p_xs_q <= PROD_W'(dx_q) * PROD_W'(sin_q);
      p_yc_q <= PROD_W'(dy_q) * PROD_W'(cos_q);
    end
  end

  // Sum stage: round half up to whole cells and test against the second grid.
  logic signed [SUM_W-1:0] sum_x_d, sum_y_d;
  logic signed [MAP_W-1:0] jx_d, jy_d, jx_q, jy_q;
  logic                    hit2_d, hit2_q;

  assign sum_x_d = SUM_W'(p_xc_q) - SUM_W'(p_ys_q) + ROUND_HALF;
  assign sum_y_d = SUM_W'(p_xs_q) + SUM_W'(p_yc_q) + ROUND_HALF;
  assign jx_d    = sum_x_d[SUM_W-1:FRAC_W];
  assign jy_d    = sum_y_d[SUM_W-1:FRAC_W];
  assign hit2_d  = !jx_d[MAP_W-1] && !jy_d[MAP_W-1] &&
                   (32'(jx_d[MAP_W-2:0]) < 32'(second_w_q)) &&
                   (32'(jy_d[MAP_W-2:0]) < 32'(second_h_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      jx_q   <= jx_d;
      jy_q   <= jy_d;
      hit2_q <= hit2_d;
    end
  end

  // Address stage: linear index into the store, wrapped to its depth.
  logic [LIN_W-1:0]  lin_d;
  logic [ADDR_W-1:0] rd_addr_q;

  assign lin_d = LIN_W'(jx_q[SIDE_W-1:0]) +
                 LIN_W'(jy_q[SIDE_W-1:0]) * LIN_W'(second_w_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_en) begin
      rd_addr_q <= ADDR_W'(lin_d);
    end
  end

  // Second grid store.
  logic [CELL_W-1:0] rd_data;

  rogm_ram #(
    .WIDTH (CELL_W),
    .DEPTH (STORE_CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_we),
    .waddr_i (ADDR_W'(load_index_i)),
    .wdata_i (load_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_data)
  );

  // Merge of the two values: unknown takes the second, otherwise the maximum.
  logic signed [CELL_W-1:0] start_val, v2, merged;

  always_comb begin
    start_val = hit1_q ? v1_q : CELL_UNKNOWN;
    v2        = rd_data;
    merged    = start_val;
    if (hit2_q) begin
      if (start_val == CELL_UNKNOWN) begin
        merged = v2;
      end else if (v2 != CELL_UNKNOWN && v2 > start_val) begin
        merged = v2;
      end
    end
  end

  // Output register.
  logic                     out_valid_q;
  logic signed [CELL_W-1:0] fused_q;
  logic                     first_hit_q, second_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      fused_q      <= merged;
      first_hit_q  <= hit1_q;
      second_hit_q <= hit2_q;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign fused_value_o = fused_q;
  assign first_hit_o   = first_hit_q;
  assign second_hit_o  = second_hit_q;

endmodule

// ----- design/rogm_checker.sv -----
// Port-level checks of the rotated occupancy grid merge unit, bound to the top.
// Depends on rogm_pkg.
`timescale 1ns / 1ps

module rogm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               kind_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [rogm_pkg::CELL_W-1:0] fused_value_o,
  input logic                               first_hit_o,
  input logic                               second_hit_o
);

  import rogm_pkg::*;

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // A load request never creates a result.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && kind_i == KIND_LOAD && !out_valid_o |=> !out_valid_o)
    else $error("load request produced a result");

  // The unit is busy in the cycle after a fuse request.
  a_fuse_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && kind_i == KIND_FUSE |=> in_stall_o)
    else $error("request taken while a fuse request is in flight");

  // A fuse result cannot appear before the mapping and store read finish.
  a_fuse_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && kind_i == KIND_FUSE && !out_valid_o |=>
      !out_valid_o ##1 !out_valid_o ##1 !out_valid_o ##1 !out_valid_o)
    else $error("fuse result appeared too early");

  // A cell outside both grids stays unknown.
  a_miss_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !first_hit_o && !second_hit_o |-> fused_value_o == CELL_UNKNOWN)
    else $error("cell outside both grids is not unknown");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fused_value_o) &&
      $stable(first_hit_o) && $stable(second_hit_o))
    else $error("stalled result changed");

endmodule

bind rotated_occupancy_grid_merge_unit rogm_checker u_rogm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .kind_i        (kind_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .fused_value_o (fused_value_o),
  .first_hit_o   (first_hit_o),
  .second_hit_o  (second_hit_o)
);

// ----- tb/tb_rotated_occupancy_grid_merge_unit.sv -----
// Testbench for the rotated occupancy grid merge unit: a queue-fed driver, an
// output monitor and an independent predictor of the merged cells.
// Depends on rogm_pkg and rotated_occupancy_grid_merge_unit.
`timescale 1ns / 1ps

module tb_rotated_occupancy_grid_merge_unit;
  import rogm_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES  = 16;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 88;

  // One request as offered on the input channel.
  typedef struct packed {
    logic                       kind;
    logic [LOAD_IDX_W-1:0]      load_index;
    logic signed [CELL_W-1:0]   load_value;
    logic signed [COORD_W-1:0]  cell_x;
    logic signed [COORD_W-1:0]  cell_y;
    logic signed [CELL_W-1:0]   first_value;
  } grid_req_t;

  // One merged cell as returned on the output channel.
  typedef struct packed {
    logic signed [CELL_W-1:0] value;
    logic                     first_hit;
    logic                     second_hit;
  } fused_cell_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  cfg_idx_t                  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      kind_i = 1'b0;
  logic [LOAD_IDX_W-1:0]     load_index_i = '0;
  logic signed [CELL_W-1:0]  load_value_i = '0;
  logic signed [COORD_W-1:0] cell_x_i = '0;
  logic signed [COORD_W-1:0] cell_y_i = '0;
  logic signed [CELL_W-1:0]  first_value_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [CELL_W-1:0]  fused_value_o;
  logic                      first_hit_o;
  logic                      second_hit_o;

  rotated_occupancy_grid_merge_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .load_index_i  (load_index_i),
    .load_value_i  (load_value_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .first_value_i (first_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .fused_value_o (fused_value_o),
    .first_hit_o   (first_hit_o),
    .second_hit_o  (second_hit_o)
  );

  // Predictor copy of the configuration and of the second grid store.
  logic signed [TRIG_W-1:0]  cfg_cos = 16'sd16384;
  logic signed [TRIG_W-1:0]  cfg_sin = '0;
  logic signed [COORD_W-1:0] cfg_shift_x = '0;
  logic signed [COORD_W-1:0] cfg_shift_y = '0;
  side_t                     first_w = side_t'(MAX_SIDE);
  side_t                     first_h = side_t'(MAX_SIDE);
  side_t                     second_w = side_t'(MAX_SIDE);
  side_t                     second_h = side_t'(MAX_SIDE);
  logic signed [CELL_W-1:0]  second_cells [0:STORE_CELLS-1];
  bit                        cell_written [0:STORE_CELLS-1];

  grid_req_t   grid_reqs[$];
  fused_cell_t due_cells[$];
  grid_req_t   offered_req;

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Clock generation.
  always #6 clk_i = ~clk_i;

  // Append a request to the tail of the pending queue.
  function automatic void append_req(input grid_req_t r);
    grid_reqs.insert(grid_reqs.size(), r);
  endfunction

  // Append a merged cell to the tail of the expected results.
  function automatic void append_due(input fused_cell_t c);
    due_cells.insert(due_cells.size(), c);
  endfunction

  // Grid sides above the maximum are held at the maximum.
  function automatic side_t limit_side(input logic [DIM_W-1:0] v);
    if (int'(v) > MAX_SIDE) begin
      return side_t'(MAX_SIDE);
    end
    return side_t'(v);
  endfunction

  // Rotate and translate a first-grid cell into the second grid.
  function automatic void project_to_second(input logic signed [COORD_W-1:0] x,
                                            input logic signed [COORD_W-1:0] y,
                                            output logic hit,
                                            output logic [ADDR_W-1:0] idx);
    longint dx, dy, jx, jy;
    dx = longint'(x) - longint'(cfg_shift_x);
    dy = longint'(y) - longint'(cfg_shift_y);
    jx = (dx * longint'(cfg_cos) - dy * longint'(cfg_sin) + 8192) >>> 14;
    jy = (dx * longint'(cfg_sin) + dy * longint'(cfg_cos) + 8192) >>> 14;
    hit = jx >= 0 && jx < longint'(second_w) && jy >= 0 && jy < longint'(second_h);
    idx = ADDR_W'(jx + jy * longint'(second_w));
  endfunction

  // Merged cell for one fuse request.
  function automatic fused_cell_t merge_cell(input grid_req_t r);
    fused_cell_t               c;
    logic signed [COORD_W-1:0] x, y;
    logic signed [CELL_W-1:0]  acc, v2;
    logic                      hit2;
    logic [ADDR_W-1:0]         idx;
    x = r.cell_x;
    y = r.cell_y;
    c.first_hit = x >= 0 && int'(x) < int'(first_w) && y >= 0 && int'(y) < int'(first_h);
    acc = c.first_hit ? r.first_value : CELL_UNKNOWN;
    project_to_second(x, y, hit2, idx);
    c.second_hit = hit2;
    if (hit2) begin
      v2 = second_cells[idx];
      if (acc == CELL_UNKNOWN) begin
        acc = v2;
      end else if (v2 != CELL_UNKNOWN && v2 > acc) begin
        acc = v2;
      end
    end
    c.value = acc;
    return c;
  endfunction

  // Apply an accepted request to the predictor.
  function automatic void absorb_req(input grid_req_t r);
    if (r.kind == KIND_LOAD) begin
      second_cells[r.load_index] = r.load_value;
    end else begin
      append_due(merge_cell(r));
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Input driver: offers queued requests, holding each until it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        absorb_req(offered_req);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (grid_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_req = grid_reqs.pop_front();
          in_valid_i    <= 1'b1;
          kind_i        <= offered_req.kind;
          load_index_i  <= offered_req.load_index;
          load_value_i  <= offered_req.load_value;
          cell_x_i      <= offered_req.cell_x;
          cell_y_i      <= offered_req.cell_y;
          first_value_i <= offered_req.first_value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each taken result and drives the stall.
  always @(posedge clk_i) begin
    fused_cell_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_cells.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, value %0d",
                                    fused_value_o));
        end else begin
          want = due_cells.pop_front();
          if (fused_value_o !== want.value) begin
            report_mismatch($sformatf("fused_value got %0d expected %0d",
                                      fused_value_o, want.value));
          end
          if (first_hit_o !== want.first_hit) begin
            report_mismatch($sformatf("first_hit got %b expected %b",
                                      first_hit_o, want.first_hit));
          end
          if (second_hit_o !== want.second_hit) begin
            report_mismatch($sformatf("second_hit got %b expected %b",
                                      second_hit_o, want.second_hit));
          end
        end
      end
      // A new hold token starts a long hold-off counted here.
      if (hold_seen != hold_token) begin
        hold_seen <= hold_token;
        hold_left <= LONG_HOLD;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [CELL_W-1:0] rand_cell();
    if ($urandom_range(3) == 0) begin
      return CELL_UNKNOWN;
    end
    return CELL_W'($urandom);
  endfunction

  // Write one register at the next edge and mirror it in the predictor.
  task automatic write_reg(input cfg_idx_t idx, input int data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(data);
    case (idx)
      CFG_COS:      cfg_cos = TRIG_W'(data);
      CFG_SIN:      cfg_sin = TRIG_W'(data);
      CFG_SHIFT_X:  cfg_shift_x = COORD_W'(data);
      CFG_SHIFT_Y:  cfg_shift_y = COORD_W'(data);
      CFG_FIRST_W:  first_w = limit_side(DIM_W'(data));
      CFG_FIRST_H:  first_h = limit_side(DIM_W'(data));
      CFG_SECOND_W: second_w = limit_side(DIM_W'(data));
      CFG_SECOND_H: second_h = limit_side(DIM_W'(data));
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int c, input int s, input int sx, input int sy,
                               input int fw, input int fh, input int sw, input int sh);
    write_reg(CFG_COS, c);
    write_reg(CFG_SIN, s);
    write_reg(CFG_SHIFT_X, sx);
    write_reg(CFG_SHIFT_Y, sy);
    write_reg(CFG_FIRST_W, fw);
    write_reg(CFG_FIRST_H, fh);
    write_reg(CFG_SECOND_W, sw);
    write_reg(CFG_SECOND_H, sh);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_load(input int idx, input logic signed [CELL_W-1:0] v);
    grid_req_t r;
    r.kind        = KIND_LOAD;
    r.load_index  = LOAD_IDX_W'(idx);
    r.load_value  = v;
    r.cell_x      = COORD_W'($urandom);
    r.cell_y      = COORD_W'($urandom);
    r.first_value = CELL_W'($urandom);
    cell_written[r.load_index] = 1'b1;
    append_req(r);
  endtask

  // Queue a fuse request; a store cell it maps onto is loaded first if needed,
  // and now and then rewritten straight after the read.
  task automatic queue_fuse(input int x, input int y, input logic signed [CELL_W-1:0] fv);
    grid_req_t         r;
    logic              hit;
    logic [ADDR_W-1:0] idx;
    r.kind        = KIND_FUSE;
    r.load_index  = LOAD_IDX_W'($urandom);
    r.load_value  = CELL_W'($urandom);
    r.cell_x      = COORD_W'(x);
    r.cell_y      = COORD_W'(y);
    r.first_value = fv;
    project_to_second(r.cell_x, r.cell_y, hit, idx);
    if (hit && !cell_written[idx]) begin
      queue_load(int'(idx), rand_cell());
    end
    append_req(r);
    if (hit && $urandom_range(99) < 15) begin
      queue_load(int'(idx), rand_cell());
    end
  endtask

  // Random mix of loads and fuse requests aimed at either grid.
  task automatic fill_random_reqs(input int n);
    int     sel, sw_hi, sh_hi, tx, ty;
    longint c, s, dx, dy;
    for (int i = 0; i < n; i++) begin
      sw_hi = (int'(second_w) > 0) ? int'(second_w) - 1 : 0;
      sh_hi = (int'(second_h) > 0) ? int'(second_h) - 1 : 0;
      sel = $urandom_range(99);
      if (sel < 25) begin
        if ($urandom_range(1) == 0) begin
          queue_load($urandom_range(0, sw_hi + sh_hi * int'(second_w)), rand_cell());
        end else begin
          queue_load(int'(LOAD_IDX_W'($urandom)), rand_cell());
        end
      end else if (sel < 65) begin
        // Pick a second-grid cell and map it back through the inverse rotation.
        c = longint'(cfg_cos);
        s = longint'(cfg_sin);
        tx = $urandom_range(0, sw_hi);
        ty = $urandom_range(0, sh_hi);
        dx = (c * tx + s * ty + 8192) >>> 14;
        dy = (c * ty - s * tx + 8192) >>> 14;
        queue_fuse(int'(dx) + int'(cfg_shift_x) + $urandom_range(0, 2) - 1,
                   int'(dy) + int'(cfg_shift_y) + $urandom_range(0, 2) - 1, rand_cell());
      end else if (sel < 90) begin
        queue_fuse($urandom_range(0, int'(first_w) + 5) - 3,
                   $urandom_range(0, int'(first_h) + 5) - 3, rand_cell());
      end else begin
        queue_fuse($urandom, $urandom, rand_cell());
      end
    end
  endtask

  // Sender pause: wait until everything queued has been taken and answered.
  task automatic wait_drain();
    while (grid_reqs.size() != 0 || in_valid_i || due_cells.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
      1: begin send_idle_pct <= 68; recv_stall_pct <= 0;  end
      2: begin send_idle_pct <= 0;  recv_stall_pct <= 68; end
      default: begin send_idle_pct <= 37; recv_stall_pct <= 37; end
    endcase
  endtask

  // Stimulus sequence.
  initial begin
    int c, s, pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests under the reset setting (identity mapping, 256 x 256).
    set_idling(0);
    queue_load(0, 8'sd127);
    queue_load(STORE_CELLS - 1, -8'sd128);
    queue_load(1, CELL_UNKNOWN);
    queue_fuse(0, 0, CELL_UNKNOWN);
    queue_fuse(255, 255, 8'sd5);
    queue_fuse(1, 0, 8'sd3);
    queue_fuse(1, 0, CELL_UNKNOWN);
    queue_fuse(0, 0, -8'sd128);
    queue_fuse(0, 0, 8'sd127);
    queue_fuse(-1, 0, 8'sd100);
    queue_fuse(256, 0, 8'sd9);
    queue_fuse(0, 256, 8'sd9);
    queue_fuse(-512, -512, 8'sd1);
    queue_fuse(511, 511, -8'sd2);
    queue_load(0, CELL_UNKNOWN);
    queue_fuse(0, 0, 8'sd50);
    queue_load(2, -8'sd128);
    queue_fuse(2, 0, -8'sd127);
    queue_fuse(2, 0, CELL_UNKNOWN);
    wait_drain();

    // Random phases, each under its own setting and idling.
    for (int p = 1; p <= 8; p++) begin
      case (p)
        1: apply_setting(16384, 0, 0, 0, 1, 1, 1, 1);
        2: apply_setting(0, 16384, 511, -512, 256, 256, 16, 8);
        3: apply_setting(-16384, 0, $urandom_range(0, 60) - 30, $urandom_range(0, 60) - 30,
                         511, 300, 511, 257);
        4: apply_setting(11585, 11585, $urandom_range(0, 40) - 20,
                         $urandom_range(0, 40) - 20, $urandom_range(1, 24),
                         $urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(1, 24));
        5: apply_setting(0, -16384, $urandom_range(0, 10) - 5, $urandom_range(0, 10) - 5,
                         0, 10, 20, 0);
        6: apply_setting(16384, 16384, $urandom_range(0, 40) - 20,
                         $urandom_range(0, 40) - 20, $urandom_range(1, 32),
                         $urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32));
        7: apply_setting(-16384, -16384, $urandom_range(0, 40) - 20,
                         $urandom_range(0, 40) - 20, $urandom_range(1, 32),
                         $urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32));
        default: begin
          pick = $urandom_range(2);
          if (pick == 0) begin
            c = 14189; s = 8192;
          end else if (pick == 1) begin
            c = 8192; s = -14189;
          end else begin
            c = $urandom_range(0, 32768) - 16384;
            s = $urandom_range(0, 32768) - 16384;
          end
          apply_setting(c, s, $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
                        $urandom_range(1, 48), $urandom_range(1, 48),
                        $urandom_range(1, 48), $urandom_range(1, 48));
        end
      endcase
      set_idling(p % 4);
      // Long receiver hold while the sender keeps offering, so the unit backs up.
      if (p == 4) begin
        hold_token <= hold_token + 1;
      end
      fill_random_reqs(PHASE_ITEMS);
      wait_drain();
    end

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/rogm_pkg.sv
design/rogm_ram.sv
design/rogm_ctrl.sv
design/rogm_dp.sv
design/rotated_occupancy_grid_merge_unit.sv
design/rogm_checker.sv
tb/tb_rotated_occupancy_grid_merge_unit.sv
